/* src/wheel_pulse_tachometer_assert.svh */
// Assertion macros shared by the tachometer RTL.
`ifndef WHEEL_PULSE_TACHOMETER_ASSERT_SVH
`define WHEEL_PULSE_TACHOMETER_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define WPT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("wpt assertion failed");
// Same-cycle implication.
`define WPT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("wpt implication failed");
// Next-cycle implication.
`define WPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wpt next-cycle check failed");
`else
`define WPT_ASSERT(lbl, clk, rst, prop)
`define WPT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define WPT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* src/wpt_pkg.sv */
// Types, constants and codes of the wheel pulse tachometer.
package wpt_pkg;

   localparam int NUM_CHANNELS_DEF = 2;

   localparam int TIME_W  = 32;
   localparam int COUNT_W = 32;
   localparam int SPEED_W = 24;
   localparam int CFG_W   = 16;
   localparam int SCALE_W = 20;
   localparam int PROD_W  = COUNT_W + SCALE_W;
   localparam int QUOT_W  = SPEED_W;
   localparam int REM_W   = TIME_W;

   // 3000 RPM per slot/ms, times 256 for Q.8
   localparam logic [SCALE_W-1:0] RPM_SCALE = SCALE_W'(3000 * 256);
   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

   localparam logic [CFG_W-1:0] SAMPLE_TIME_RST = CFG_W'(100);
   localparam logic [CFG_W-1:0] DEBOUNCE_RST    = CFG_W'(500);

   typedef enum logic [1:0] {
      OP_EDGE    = 2'd0,
      OP_SPEED   = 2'd1,
      OP_ENABLE  = 2'd2,
      OP_DISABLE = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_SAMPLE_TIME = 1'b0,
      CSR_DEBOUNCE    = 1'b1
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_FIN
   } state_type;

   // sequencer -> datapath
   typedef struct packed {
      logic ready;
      logic eval;
      logic mul;
      logic check;
      logic div_start;
      logic commit;
   } ctrl_type;

   // datapath -> sequencer
   typedef struct packed {
      logic req_valid;
      logic need_div;
      logic sat;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

/* src/wpt_if.sv */
// Channel interfaces: request, response and register write.
interface wpt_req_if import wpt_pkg::*; ();
   logic               valid;
   logic               ready;
   opcode_type         opcode;
   logic               channel;
   logic [TIME_W-1:0]  time_us;
   logic [TIME_W-1:0]  time_ms;

   modport source (output valid, opcode, channel, time_us, time_ms, input ready);
   modport sink   (input valid, opcode, channel, time_us, time_ms, output ready);
endinterface

interface wpt_rsp_if import wpt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               out_channel;
   logic [COUNT_W-1:0] gap_count;
   logic [SPEED_W-1:0] speed_rpm_q8;

   modport source (output valid, out_channel, gap_count, speed_rpm_q8, input ready);
   modport sink   (input valid, out_channel, gap_count, speed_rpm_q8, output ready);
endinterface

interface wpt_csr_if import wpt_pkg::*; ();
   logic               valid;
   logic               ready;
   csr_idx_type        index;
   logic [CFG_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* src/wheel_pulse_tachometer.sv */
// Top level of the two-channel wheel pulse tachometer.
// Each request transaction (edge, speed request, enable, disable) returns one
// response with the channel's slot count and last speed in Q16.8 RPM. One
// transaction is in work at a time: edge, enable, disable and speed requests
// that do not recompute go through evaluate and commit; a recomputing speed
// request also multiplies, checks for saturation and, unless it saturates,
// runs the 24-step shift-subtract divider shared by both channels. A waiting
// response does not stop the next request from being accepted. The register
// port is always ready and should be written only while no request is pending.
`include "wheel_pulse_tachometer_assert.svh"

module wheel_pulse_tachometer import wpt_pkg::*; #(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   wpt_req_if.sink    req_ch,
   wpt_rsp_if.source  rsp_ch,
   wpt_csr_if.sink    csr_ch
);

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   ctrl_type ctrl;
   stat_type stat;

   // configuration
   logic [CFG_W-1:0] sample_time_ff, sample_time_in;
   logic [CFG_W-1:0] debounce_ff, debounce_in;

   // per-channel state
   logic [SPEED_W-1:0] speed_store_ff [NUM_CHANNELS];
   logic [SPEED_W-1:0] speed_store_in [NUM_CHANNELS];
   logic [TIME_W-1:0]  last_sample_ff [NUM_CHANNELS];
   logic [TIME_W-1:0]  last_sample_in [NUM_CHANNELS];
   logic [TIME_W-1:0]  last_edge_ff   [NUM_CHANNELS];
   logic [TIME_W-1:0]  last_edge_in   [NUM_CHANNELS];
   logic               enable_ff      [NUM_CHANNELS];
   logic               enable_in      [NUM_CHANNELS];
   logic [COUNT_W-1:0] slot_count_ff  [NUM_CHANNELS];
   logic [COUNT_W-1:0] slot_count_in  [NUM_CHANNELS];
   logic [COUNT_W-1:0] count_samp_ff  [NUM_CHANNELS];
   logic [COUNT_W-1:0] count_samp_in  [NUM_CHANNELS];

   // latched transaction
   opcode_type        op_ff, op_in;
   logic              ch_ff, ch_in;
   logic [TIME_W-1:0] time_us_ff, time_us_in;
   logic [TIME_W-1:0] time_ms_ff, time_ms_in;

   logic               recompute_ff, recompute_in;
   logic               sat_ff, sat_in;
   logic [PROD_W-1:0]  product_ff, product_in;
   logic [REM_W-1:0]   divisor_ff, divisor_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_channel_ff, rsp_channel_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;

   logic               accept;
   logic               in_range;
   logic [IDX_W-1:0]   idx;
   logic [TIME_W-1:0]  elapsed_ms;
   logic [TIME_W-1:0]  elapsed_us;
   logic [COUNT_W-1:0] delta;
   logic               sat_now;
   logic               div_done;
   logic [QUOT_W-1:0]  quotient;
   logic [COUNT_W-1:0] new_count;
   logic [SPEED_W-1:0] new_speed;

   assign accept     = req_ch.valid && req_ch.ready;
   assign in_range   = 32'(ch_ff) < NUM_CHANNELS;
   assign idx        = IDX_W'(ch_ff);
   assign elapsed_ms = time_ms_ff - last_sample_ff[idx];
   assign elapsed_us = time_us_ff - last_edge_ff[idx];
   assign delta      = slot_count_ff[idx] - count_samp_ff[idx];
   assign sat_now    = REM_W'(product_ff[PROD_W-1:QUOT_W]) >= divisor_ff;

   assign stat.req_valid = req_ch.valid;
   assign stat.need_div  = in_range && (op_ff == OP_SPEED)
                           && (elapsed_ms > TIME_W'(sample_time_ff));
   assign stat.sat       = sat_now;
   assign stat.div_done  = div_done;
   assign stat.out_free  = !rsp_valid_ff || rsp_ch.ready;

   wpt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   wpt_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (ctrl.div_start),
      .rem_init    (REM_W'(product_ff[PROD_W-1:QUOT_W])),
      .dividend_lo (product_ff[QUOT_W-1:0]),
      .divisor     (divisor_ff),
      .done        (div_done),
      .quotient    (quotient)
   );

   // configuration writes
   always_comb begin
      sample_time_in = sample_time_ff;
      debounce_in    = debounce_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SAMPLE_TIME: sample_time_in = csr_ch.data;
            CSR_DEBOUNCE:    debounce_in    = csr_ch.data;
            default:         sample_time_in = sample_time_ff;
         endcase
      end
   end

   // transaction capture and arithmetic operands
   always_comb begin
      op_in        = op_ff;
      ch_in        = ch_ff;
      time_us_in   = time_us_ff;
      time_ms_in   = time_ms_ff;
      recompute_in = recompute_ff;
      sat_in       = sat_ff;
      product_in   = product_ff;
      divisor_in   = divisor_ff;
      if (accept) begin
         op_in      = req_ch.opcode;
         ch_in      = req_ch.channel;
         time_us_in = req_ch.time_us;
         time_ms_in = req_ch.time_ms;
      end
      if (ctrl.eval) begin
         recompute_in = stat.need_div;
         sat_in       = 1'b0;
      end
      if (ctrl.mul) begin
         product_in = PROD_W'(delta) * PROD_W'(RPM_SCALE);
         divisor_in = elapsed_ms;
      end
      if (ctrl.check) begin
         sat_in = sat_now;
      end
   end

   // channel state update at commit
   always_comb begin
      speed_store_in = speed_store_ff;
      last_sample_in = last_sample_ff;
      last_edge_in   = last_edge_ff;
      enable_in      = enable_ff;
      slot_count_in  = slot_count_ff;
      count_samp_in  = count_samp_ff;
      new_count      = slot_count_ff[idx];
      new_speed      = speed_store_ff[idx];
      case (op_ff)
         OP_EDGE: begin
            if ((elapsed_us > TIME_W'(debounce_ff)) && enable_ff[idx]) begin
               new_count = slot_count_ff[idx] + 1'b1;
            end
         end
         OP_SPEED: begin
            if (recompute_ff) begin
               new_speed = sat_ff ? SPEED_MAX : quotient;
            end
         end
         OP_DISABLE: new_count = '0;
         default:    new_count = slot_count_ff[idx];
      endcase
      if (!in_range) begin
         new_count = '0;
         new_speed = '0;
      end
      if (ctrl.commit && in_range) begin
         slot_count_in[idx]  = new_count;
         speed_store_in[idx] = new_speed;
         case (op_ff)
            OP_EDGE: begin
               if (elapsed_us > TIME_W'(debounce_ff)) begin
                  last_edge_in[idx] = time_us_ff;
               end
            end
            OP_SPEED: begin
               if (recompute_ff) begin
                  last_sample_in[idx] = time_ms_ff;
                  count_samp_in[idx]  = slot_count_ff[idx];
               end
            end
            OP_ENABLE:  enable_in[idx] = 1'b1;
            OP_DISABLE: enable_in[idx] = 1'b0;
            default:    enable_in[idx] = enable_ff[idx];
         endcase
      end
   end

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_channel_in = rsp_channel_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_speed_in   = rsp_speed_ff;
      if (ctrl.commit) begin
         rsp_valid_in   = 1'b1;
         rsp_channel_in = ch_ff;
         rsp_count_in   = new_count;
         rsp_speed_in   = new_speed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_time_ff <= SAMPLE_TIME_RST;
         debounce_ff    <= DEBOUNCE_RST;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            speed_store_ff[i] <= '0;
            last_sample_ff[i] <= '0;
            last_edge_ff[i]   <= '0;
            enable_ff[i]      <= 1'b0;
            slot_count_ff[i]  <= '0;
            count_samp_ff[i]  <= '0;
         end
      end else begin
         sample_time_ff <= sample_time_in;
         debounce_ff    <= debounce_in;
         rsp_valid_ff   <= rsp_valid_in;
         speed_store_ff <= speed_store_in;
         last_sample_ff <= last_sample_in;
         last_edge_ff   <= last_edge_in;
         enable_ff      <= enable_in;
         slot_count_ff  <= slot_count_in;
         count_samp_ff  <= count_samp_in;
      end
      op_ff          <= op_in;
      ch_ff          <= ch_in;
      time_us_ff     <= time_us_in;
      time_ms_ff     <= time_ms_in;
      recompute_ff   <= recompute_in;
      sat_ff         <= sat_in;
      product_ff     <= product_in;
      divisor_ff     <= divisor_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_speed_ff   <= rsp_speed_in;
   end

   assign req_ch.ready        = ctrl.ready;
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.out_channel  = rsp_channel_ff;
   assign rsp_ch.gap_count    = rsp_count_ff;
   assign rsp_ch.speed_rpm_q8 = rsp_speed_ff;

   `WPT_ASSERT_NEXT(a_one_in_flight, clock, reset, accept, !req_ch.ready)
   `WPT_ASSERT_NEXT(a_commit_shows, clock, reset, ctrl.commit, rsp_ch.valid)
   `WPT_ASSERT_NEXT(a_count_holds, clock, reset, !ctrl.commit,
                    $stable(slot_count_ff[0]))
   `WPT_ASSERT(a_div_only_on_speed, clock, reset,
               !ctrl.div_start || (op_ff == OP_SPEED && recompute_ff))

endmodule

/* src/wpt_div.sv */
// Shift-subtract divider, one quotient bit per cycle.
`include "wheel_pulse_tachometer_assert.svh"

module wpt_div import wpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [REM_W-1:0]  rem_init,
   input  logic [QUOT_W-1:0] dividend_lo,
   input  logic [REM_W-1:0]  divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUOT_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(QUOT_W - 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  div_ff, div_in;
   logic [QUOT_W-1:0] low_ff, low_in;
   logic [REM_W:0]    shifted;
   logic [REM_W:0]    diff;
   logic              fits;

   always_comb begin
      shifted = {rem_ff, low_ff[QUOT_W-1]};
      diff    = shifted - {1'b0, div_ff};
      fits    = shifted >= {1'b0, div_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      low_in  = low_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = rem_init;
         div_in  = divisor;
         low_in  = dividend_lo;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits REM_W bits
         rem_in  = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         low_in  = {low_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff + 1'b1;
         busy_in = (cnt_ff != LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      low_ff <= low_in;
   end

   assign done     = busy_ff && (cnt_ff == LAST);
   assign quotient = low_ff;

   `WPT_ASSERT_IMPL(a_rem_below_div, clock, reset, busy_ff, rem_ff < div_ff)
   `WPT_ASSERT_IMPL(a_div_latency, clock, reset, start, ##(QUOT_W) done)
   `WPT_ASSERT_NEXT(a_done_frees, clock, reset, done, !busy_ff)

endmodule

/* src/wpt_seq.sv */
// Sequencer stepping one transaction through evaluate, multiply, saturation check, divide, commit.
module wpt_seq import wpt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (stat.req_valid) state_in = ST_EVAL;
         ST_EVAL:  state_in = stat.need_div ? ST_MUL : ST_FIN;
         ST_MUL:   state_in = ST_CHECK;
         ST_CHECK: state_in = stat.sat ? ST_FIN : ST_DIV;
         ST_DIV:   if (stat.div_done) state_in = ST_FIN;
         ST_FIN:   if (stat.out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:  ctrl.ready     = 1'b1;
         ST_EVAL:  ctrl.eval      = 1'b1;
         ST_MUL:   ctrl.mul       = 1'b1;
         ST_CHECK: begin
            ctrl.check     = 1'b1;
            ctrl.div_start = !stat.sat;
         end
         ST_DIV:   ctrl = '0;
         ST_FIN:   ctrl.commit    = stat.out_free;
         default:  ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* tb/sv/wheel_pulse_tachometer_checker.sv */
// Checker for the wheel tachometer: tracks per-channel state and scores every response.
module wheel_pulse_tachometer_checker import wpt_pkg::*; (
   input  logic clock,
   input  logic reset,
   wpt_req_if   req_ch,
   wpt_rsp_if   rsp_ch,
   wpt_csr_if   csr_ch,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] RPM_Q8_PER_SLOT_MS = 64'd3000 * 64'd256;

   typedef struct packed {
      logic               channel;
      logic [COUNT_W-1:0] count;
      logic [SPEED_W-1:0] speed;
   } tach_reading_type;

   logic [CFG_W-1:0]   cfg_sample_ms;
   logic [CFG_W-1:0]   cfg_debounce_us;
   logic [SPEED_W-1:0] speed_q8        [2];
   logic [TIME_W-1:0]  sample_ms_mark  [2];
   logic [TIME_W-1:0]  edge_us_mark    [2];
   logic               counting        [2];
   logic [COUNT_W-1:0] slots           [2];
   logic [COUNT_W-1:0] slots_at_sample [2];

   tach_reading_type readings_due[$];
   int               errors;

   // Applies one request to the channel state and returns the response it owes.
   function automatic tach_reading_type next_reading(opcode_type op, logic ch,
                                                     logic [TIME_W-1:0] t_us,
                                                     logic [TIME_W-1:0] t_ms);
      logic [TIME_W-1:0]  us_gap;
      logic [TIME_W-1:0]  ms_gap;
      logic [COUNT_W-1:0] slot_gap;
      logic [63:0]        quot;
      tach_reading_type   r;
      case (op)
         OP_EDGE: begin
            us_gap = t_us - edge_us_mark[ch];
            if (us_gap > TIME_W'(cfg_debounce_us)) begin
               edge_us_mark[ch] = t_us;
               if (counting[ch])
                  slots[ch] = slots[ch] + 1'b1;
            end
         end
         OP_SPEED: begin
            ms_gap = t_ms - sample_ms_mark[ch];
            if (ms_gap > TIME_W'(cfg_sample_ms)) begin
               // count difference is modulo 2^32, so a clear after a sample saturates
               slot_gap = slots[ch] - slots_at_sample[ch];
               quot = (64'(slot_gap) * RPM_Q8_PER_SLOT_MS) / 64'(ms_gap);
               speed_q8[ch] = (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[SPEED_W-1:0];
               sample_ms_mark[ch] = t_ms;
               slots_at_sample[ch] = slots[ch];
            end
         end
         OP_ENABLE: begin
            counting[ch] = 1'b1;
         end
         OP_DISABLE: begin
            counting[ch] = 1'b0;
            slots[ch] = '0;
         end
         default: begin
         end
      endcase
      r.channel = ch;
      r.count = slots[ch];
      r.speed = speed_q8[ch];
      return r;
   endfunction

   always @(posedge clock) begin
      tach_reading_type exp_rd;
      if (reset) begin
         cfg_sample_ms = SAMPLE_TIME_RST;
         cfg_debounce_us = DEBOUNCE_RST;
         for (int i = 0; i < 2; i++) begin
            speed_q8[i] = '0;
            sample_ms_mark[i] = '0;
            edge_us_mark[i] = '0;
            counting[i] = 1'b0;
            slots[i] = '0;
            slots_at_sample[i] = '0;
         end
         readings_due.delete();
         errors = 0;
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_SAMPLE_TIME: cfg_sample_ms = csr_ch.data;
               CSR_DEBOUNCE:    cfg_debounce_us = csr_ch.data;
               default: begin
               end
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (readings_due.size() == 0) begin
               $display("%0t: response with none outstanding: ch %0d count %0d speed %0h",
                        $time, rsp_ch.out_channel, rsp_ch.gap_count, rsp_ch.speed_rpm_q8);
               errors++;
            end else begin
               exp_rd = readings_due.pop_front();
               if (rsp_ch.out_channel !== exp_rd.channel) begin
                  $display("%0t: out_channel expected %0d, got %0d",
                           $time, exp_rd.channel, rsp_ch.out_channel);
                  errors++;
               end
               if (rsp_ch.gap_count !== exp_rd.count) begin
                  $display("%0t: gap_count expected %0d, got %0d",
                           $time, exp_rd.count, rsp_ch.gap_count);
                  errors++;
               end
               if (rsp_ch.speed_rpm_q8 !== exp_rd.speed) begin
                  $display("%0t: speed_rpm_q8 expected %0h, got %0h",
                           $time, exp_rd.speed, rsp_ch.speed_rpm_q8);
                  errors++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            readings_due.push_back(next_reading(req_ch.opcode, req_ch.channel,
                                                req_ch.time_us, req_ch.time_ms));
         fail_count <= errors;
         pending <= readings_due.size();
      end
   end

endmodule

/* tb/sv/wheel_pulse_tachometer_tb.sv */
// Testbench top for the wheel tachometer: clock, reset, stimulus, receiver stalls, verdict.
module wheel_pulse_tachometer_tb import wpt_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 40;

   logic clock;
   logic reset;

   wpt_req_if req_ch();
   wpt_rsp_if rsp_ch();
   wpt_csr_if csr_ch();

   int fail_count;
   int pending;

   int                tx_idle_pct;
   int                rx_idle_pct;
   logic              hold_toggle;
   logic              hold_seen;
   int                hold_left;
   int                idle_cycles;
   logic [TIME_W-1:0] cur_us;
   logic [TIME_W-1:0] cur_ms;
   int unsigned       lim_sample;
   int unsigned       lim_debounce;

   wheel_pulse_tachometer u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   wheel_pulse_tachometer_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Response side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_seen <= hold_toggle;
         hold_left <= 0;
      end else if (hold_seen != hold_toggle) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic issue_op(input opcode_type op, input logic ch,
                           input logic [TIME_W-1:0] t_us, input logic [TIME_W-1:0] t_ms);
      int gap;
      gap = 0;
      while (gap < 8 && $urandom_range(99) < tx_idle_pct)
         gap++;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.opcode  <= op;
      req_ch.channel <= ch;
      req_ch.time_us <= t_us;
      req_ch.time_ms <= t_ms;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Steps past the current clock edge first so the pending count includes the transaction accepted just now.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Both registers in one burst so valid stays high between the two transactions.
   task automatic program_limits(input logic [CFG_W-1:0] sample_ms,
                                 input logic [CFG_W-1:0] debounce);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_SAMPLE_TIME;
      csr_ch.data  <= sample_ms;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      csr_ch.index <= CSR_DEBOUNCE;
      csr_ch.data  <= debounce;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      csr_ch.valid <= 1'b0;
      lim_sample = sample_ms;
      lim_debounce = debounce;
      cur_us = $urandom;
      cur_ms = $urandom;
   endtask

   // Mostly a running clock stepped around the debounce and sample windows;
   // a few jumps to arbitrary times exercise wrap and huge elapsed values.
   task automatic random_op();
      int         pick;
      logic       ch;
      opcode_type op;
      pick = $urandom_range(99);
      ch = 1'($urandom_range(1));
      if (pick < 55)
         op = OP_EDGE;
      else if (pick < 78)
         op = OP_SPEED;
      else if (pick < 93)
         op = OP_ENABLE;
      else
         op = OP_DISABLE;
      pick = $urandom_range(99);
      if (pick < 4) begin
         cur_us = $urandom;
         cur_ms = $urandom;
      end else if (pick < 14) begin
         cur_us = cur_us + lim_debounce + $urandom_range(1);
      end else begin
         cur_us = cur_us + $urandom_range(2 * lim_debounce + 2);
      end
      cur_ms = cur_ms + $urandom_range(lim_sample / 8 + 2);
      issue_op(op, ch, cur_us, cur_ms);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_EDGE;
      req_ch.channel = 1'b0;
      req_ch.time_us = '0;
      req_ch.time_ms = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_SAMPLE_TIME;
      csr_ch.data = '0;
      hold_toggle = 1'b0;
      tx_idle_pct = 33;
      rx_idle_pct = 54;
      lim_sample = SAMPLE_TIME_RST;
      lim_debounce = DEBOUNCE_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset limits: 100 ms sample time, 500 us debounce.
      issue_op(OP_EDGE,    1'b0, 32'd1000, 32'd0);         // disabled edge, time kept
      issue_op(OP_SPEED,   1'b0, 32'd1000, 32'd50);        // too soon
      issue_op(OP_ENABLE,  1'b0, 32'd1000, 32'd50);
      issue_op(OP_ENABLE,  1'b1, 32'd1000, 32'd50);
      issue_op(OP_EDGE,    1'b0, 32'd1500, 32'd60);        // exactly debounce: rejected
      issue_op(OP_EDGE,    1'b0, 32'd1501, 32'd60);
      issue_op(OP_EDGE,    1'b0, 32'd2002, 32'd70);
      issue_op(OP_SPEED,   1'b0, 32'd2002, 32'd100);       // exactly sample time
      issue_op(OP_SPEED,   1'b0, 32'd2002, 32'd101);
      issue_op(OP_EDGE,    1'b1, 32'hFFFF_FF00, 32'd101);
      issue_op(OP_EDGE,    1'b1, 32'h0000_0100, 32'd101);  // microsecond wrap
      issue_op(OP_SPEED,   1'b1, 32'd0, 32'hFFFF_FFFF);
      issue_op(OP_SPEED,   1'b1, 32'd0, 32'h0000_0070);    // millisecond wrap
      issue_op(OP_DISABLE, 1'b0, 32'd2002, 32'd200);
      issue_op(OP_ENABLE,  1'b0, 32'd2002, 32'd200);
      issue_op(OP_EDGE,    1'b0, 32'd3000, 32'd200);
      issue_op(OP_SPEED,   1'b0, 32'd3000, 32'd300);       // negative delta saturates
      issue_op(OP_EDGE,    1'b0, 32'hFFFF_FFFF, 32'd300);
      issue_op(OP_DISABLE, 1'b1, 32'd0, 32'd300);
      issue_op(OP_EDGE,    1'b1, 32'h0001_0000, 32'd300);  // disabled, time recorded
      issue_op(OP_ENABLE,  1'b1, 32'h0001_0000, 32'd300);
      issue_op(OP_EDGE,    1'b1, 32'h0001_0100, 32'd300);  // within debounce of that edge
      issue_op(OP_EDGE,    1'b1, 32'h0001_0300, 32'd300);
      drain();

      program_limits('0, '0);
      repeat (560) random_op();
      drain();

      tx_idle_pct = 54;
      rx_idle_pct <= 33;
      program_limits('1, '1);
      repeat (560) random_op();
      drain();

      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      program_limits(CFG_W'($urandom_range(400, 1)), CFG_W'($urandom_range(3000, 1)));
      repeat (280) random_op();
      hold_toggle <= ~hold_toggle;
      repeat (280) random_op();
      drain();

      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
